>>> rtl/msort_pkg.sv
// types, sizes and sequencer states shared by the merge sort engine
`default_nettype none
package msort_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = ADDR_W + 1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_START,
    ST_RUN_INIT,
    ST_FETCH,
    ST_MERGE,
    ST_OUT_FETCH,
    ST_OUT_SHOW
  } state_t;

endpackage
`default_nettype wire

>>> rtl/msort_in_if.sv
// input channel: one list element per item
`default_nettype none
interface msort_in_if import msort_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/msort_out_if.sv
// output channel: one sorted element per item
`default_nettype none
interface msort_out_if import msort_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_res;
  logic  overflow;

  modport source (output valid, output sorted_value, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_res, input overflow,
                output ready);
endinterface
`default_nettype wire

>>> rtl/msort_ram.sv
// generic ram, one write port and two registered read ports
`default_nettype none
module msort_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

>>> rtl/merge_sort_engine_core.sv
// merge sort engine: load, bottom-up merge passes over two ram banks, drain
//
//  channel  dir  handshake      payload
//  din      in   valid/ready    value, last
//  dout     out  valid/ready    sorted_value, last_res, overflow
//
// loading fills bank 0 from din; din.ready is high only while loading
// each merge pass steps through ST_FETCH (bank read) and ST_MERGE (compare and
// write via the single comparator) per element, plus ST_RUN_INIT per run pair
// n items take ceil(log2 n) passes; results drain as ST_OUT_FETCH, ST_OUT_SHOW
// rst is synchronous; dout stalls hold the sequencer and the shown result
`default_nettype none
module merge_sort_engine_core import msort_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  msort_in_if.sink  din,
  msort_out_if.source dout
);

  state_t state, state_next;
  cnt_t   count, count_next;
  logic   dropped, dropped_next;
  cnt_t   width, width_next;
  cnt_t   lo, lo_next;
  cnt_t   mid, mid_next;
  cnt_t   hi, hi_next;
  cnt_t   i, i_next;
  cnt_t   j, j_next;
  cnt_t   k, k_next;
  cnt_t   o, o_next;
  logic   src, src_next;

  logic  we0, we1;
  addr_t waddr, raddr_a, raddr_b;
  data_t wdata;
  data_t rd0_a, rd0_b, rd1_a, rd1_b;
  data_t rda, rdb;
  logic  take_b;
  cnt_t  width2, lo_w, lo_w2, k_inc;

  msort_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_W)) u_bank0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  msort_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_W)) u_bank1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  assign rda    = src ? rd1_a : rd0_a;
  assign rdb    = src ? rd1_b : rd0_b;
  assign take_b = (j < hi) && ((i >= mid) || (rdb < rda));
  assign width2 = {width[CNT_W-2:0], 1'b0};
  assign lo_w   = lo + width;
  assign lo_w2  = lo + width2;
  assign k_inc  = k + 1'b1;

  assign dout.sorted_value = rda;
  assign dout.last_res     = ((o + 1'b1) == count);
  assign dout.overflow     = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    width <= width_next;
    lo    <= lo_next;
    mid   <= mid_next;
    hi    <= hi_next;
    i     <= i_next;
    j     <= j_next;
    k     <= k_next;
    o     <= o_next;
    src   <= src_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    width_next   = width;
    lo_next      = lo;
    mid_next     = mid;
    hi_next      = hi;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    o_next       = o;
    src_next     = src;
    we0          = 1'b0;
    we1          = 1'b0;
    waddr        = k[ADDR_W-1:0];
    wdata        = take_b ? rdb : rda;
    raddr_a      = i[ADDR_W-1:0];
    raddr_b      = j[ADDR_W-1:0];
    din.ready    = 1'b0;
    dout.valid   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        din.ready = 1'b1;
        if (din.valid) begin
          if (count < CNT_W'(MAX_ITEMS)) begin
            we0        = 1'b1;
            waddr      = count[ADDR_W-1:0];
            wdata      = din.value;
            count_next = count + 1'b1;
          end else begin
            dropped_next = 1'b1;
          end
          if (din.last) begin
            state_next = ST_SORT_START;
          end
        end
      end
      ST_SORT_START: begin
        width_next = CNT_W'(1);
        lo_next    = '0;
        src_next   = 1'b0;
        o_next     = '0;
        if (count <= CNT_W'(1)) begin
          state_next = ST_OUT_FETCH;
        end else begin
          state_next = ST_RUN_INIT;
        end
      end
      ST_RUN_INIT: begin
        mid_next   = (lo_w > count) ? count : lo_w;
        hi_next    = (lo_w2 > count) ? count : lo_w2;
        i_next     = lo;
        j_next     = (lo_w > count) ? count : lo_w;
        k_next     = lo;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        we0    = src;
        we1    = !src;
        k_next = k_inc;
        if (take_b) begin
          j_next = j + 1'b1;
        end else begin
          i_next = i + 1'b1;
        end
        if (k_inc == hi) begin
          if (lo_w2 >= count) begin
            width_next = width2;
            src_next   = !src;
            lo_next    = '0;
            o_next     = '0;
            if (width2 >= count) begin
              state_next = ST_OUT_FETCH;
            end else begin
              state_next = ST_RUN_INIT;
            end
          end else begin
            lo_next    = lo_w2;
            state_next = ST_RUN_INIT;
          end
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_OUT_FETCH: begin
        raddr_a    = o[ADDR_W-1:0];
        state_next = ST_OUT_SHOW;
      end
      ST_OUT_SHOW: begin
        raddr_a    = o[ADDR_W-1:0];
        dout.valid = 1'b1;
        if (dout.ready) begin
          if ((o + 1'b1) == count) begin
            count_next   = '0;
            dropped_next = 1'b0;
            state_next   = ST_IDLE;
          end else begin
            o_next     = o + 1'b1;
            state_next = ST_OUT_FETCH;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (count != '0) && (o < count))
    else $error("result shown with no stored element behind it");

  a_merge_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> (k < hi) && (i <= mid) && (j <= hi) && (k == i + j - mid))
    else $error("merge indexes out of step");

  a_batch_close: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.ready && dout.last_res) |=> (state == ST_IDLE) && (count == '0)
      && !dropped)
    else $error("batch state not cleared after final item");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) && (state != ST_OUT_SHOW) |=> $stable(count))
    else $error("element count moved while sorting");
`endif

endmodule
`default_nettype wire
